/* sv/hold_lock_and_massage_phase_ticker_core_defines.svh */
// -----------------------------------------------------------------------------
// Hold, lock and massage phase ticker - assertion macros
// Shared concurrent assertion forms for the block's checker.
// -----------------------------------------------------------------------------
`ifndef HOLD_LOCK_AND_MASSAGE_PHASE_TICKER_CORE_DEFINES_SVH
`define HOLD_LOCK_AND_MASSAGE_PHASE_TICKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HLMPT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hlmpt check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HLMPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hlmpt check failed");

`endif

/* sv/hlmpt_pkg.sv */
// -----------------------------------------------------------------------------
// Hold, lock and massage phase ticker - package
// Widths, defaults and the structs passed between the block's modules.
// -----------------------------------------------------------------------------
`default_nettype none

package hlmpt_pkg;

  localparam int unsigned PHASE_STEPS_DEF = 16;
  localparam int unsigned COUNT_BITS_DEF  = 16;

  localparam int unsigned NUM_TIMERS    = 8;
  localparam int unsigned SLOT_W        = 3;
  localparam int unsigned VALUE_W       = 16;
  localparam int unsigned INTEN_W       = 8;
  localparam int unsigned LEVEL_W       = 9;
  localparam int unsigned PHASE_W       = 8;
  localparam int unsigned PHASE_ENTRIES = 2 ** PHASE_W;
  localparam int unsigned ROT_W         = 2;
  localparam int unsigned CFG_IDX_W     = 3;

  // Fixed-point scale of the phase fraction table
  localparam int unsigned FRAC_SHIFT = 16;
  localparam int unsigned FRAC_W     = FRAC_SHIFT + 1;

  typedef struct packed {
    logic [INTEN_W-1:0] min_drive;
    logic [VALUE_W-1:0] lock_hold;
    logic [VALUE_W-1:0] unlock_hold;
    logic [VALUE_W-1:0] led_flash;
    logic [VALUE_W-1:0] mode_hold;
    logic [VALUE_W-1:0] phase_step;
    logic [VALUE_W-1:0] tick_per_sec;
  } cfg_t;

  typedef struct packed {
    logic                  locked;
    logic                  massage_stop;
    logic [NUM_TIMERS-1:0] busy_mask;
  } timer_res_t;

  typedef struct packed {
    logic [ROT_W-1:0]   rotation;
    logic               rising;
    logic [PHASE_W-1:0] phase;
    logic [LEVEL_W-1:0] in_level;
    logic [LEVEL_W-1:0] out_level;
    logic [LEVEL_W-1:0] steady_level;
  } ramp_res_t;

endpackage

`default_nettype wire

/* sv/hlmpt_cfg.sv */
// -----------------------------------------------------------------------------
// Hold, lock and massage phase ticker - configuration registers
// Decodes register writes and holds the seven control registers.
// -----------------------------------------------------------------------------
`default_nettype none

module hlmpt_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [hlmpt_pkg::CFG_IDX_W-1:0] wr_idx_i,
  input  logic [hlmpt_pkg::VALUE_W-1:0]   wr_data_i,
  output hlmpt_pkg::cfg_t                 cfg_o
);
  import hlmpt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] IdxMinDrive   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] IdxLockHold   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] IdxUnlockHold = 3'd2;
  localparam logic [CFG_IDX_W-1:0] IdxLedFlash   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] IdxModeHold   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] IdxPhaseStep  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] IdxTickPerSec = 3'd6;

  localparam cfg_t CfgReset = '{
    min_drive:    8'd0,
    lock_hold:    16'd4500,
    unlock_hold:  16'd8000,
    led_flash:    16'd1000,
    mode_hold:    16'd3000,
    phase_step:   16'd100,
    tick_per_sec: 16'd1000
  };

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_idx_i)
        IdxMinDrive:   cfg_d.min_drive    = wr_data_i[INTEN_W-1:0];
        IdxLockHold:   cfg_d.lock_hold    = wr_data_i;
        IdxUnlockHold: cfg_d.unlock_hold  = wr_data_i;
        IdxLedFlash:   cfg_d.led_flash    = wr_data_i;
        IdxModeHold:   cfg_d.mode_hold    = wr_data_i;
        IdxPhaseStep:  cfg_d.phase_step   = wr_data_i;
        IdxTickPerSec: cfg_d.tick_per_sec = wr_data_i;
        default:       cfg_d = cfg_q;  // unmapped index: dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* sv/hlmpt_timers.sv */
// -----------------------------------------------------------------------------
// Hold, lock and massage phase ticker - countdowns and button holds
// Eight countdown timers, seconds prescaler, lock toggle and mode hold.
// -----------------------------------------------------------------------------
`default_nettype none

module hlmpt_timers #(
  parameter int unsigned CountBits = hlmpt_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          load_i,
  input  logic [hlmpt_pkg::SLOT_W-1:0]  slot_i,
  input  logic [hlmpt_pkg::VALUE_W-1:0] load_value_i,
  input  logic                          lock_pressed_i,
  input  logic                          mode_pressed_i,
  input  hlmpt_pkg::cfg_t               cfg_i,
  output hlmpt_pkg::timer_res_t         res_o
);
  import hlmpt_pkg::*;

  localparam int unsigned LedSlot      = 4;
  localparam int unsigned FirstSecSlot = 5;

  logic [CountBits-1:0] cnt_q [NUM_TIMERS];
  logic [CountBits-1:0] cnt_d [NUM_TIMERS];
  logic [CountBits-1:0] dec   [NUM_TIMERS];
  logic [CountBits-1:0] sec_q, sec_d;
  logic [CountBits-1:0] lock_cnt_q, lock_cnt_d;
  logic [CountBits-1:0] mode_cnt_q, mode_cnt_d;
  logic                 latched_q, latched_d;
  logic                 locked_q, locked_d;
  logic                 stop;

  always_comb begin
    for (int unsigned i = 0; i < NUM_TIMERS; i++) begin
      dec[i] = (cnt_q[i] != '0) ? cnt_q[i] - CountBits'(1) : '0;
    end
  end

  always_comb begin
    cnt_d      = cnt_q;
    sec_d      = sec_q;
    lock_cnt_d = lock_cnt_q;
    mode_cnt_d = mode_cnt_q;
    latched_d  = latched_q;
    locked_d   = locked_q;
    stop       = 1'b0;
    if (load_i) begin
      cnt_d[slot_i] = CountBits'(load_value_i);
    end else begin
      for (int unsigned i = 0; i < FirstSecSlot; i++) begin
        cnt_d[i] = dec[i];
      end
      if (sec_q != '0) begin
        sec_d = sec_q - CountBits'(1);
      end else begin
        sec_d = CountBits'(cfg_i.tick_per_sec);
        for (int unsigned i = FirstSecSlot; i < NUM_TIMERS; i++) begin
          cnt_d[i] = dec[i];
        end
      end

      // lock toggles once per press; unlock restarts the LED flash
      if (lock_pressed_i) begin
        if (!latched_q) begin
          if (lock_cnt_q != '0) begin
            lock_cnt_d = lock_cnt_q - CountBits'(1);
          end else begin
            latched_d = 1'b1;
            locked_d  = !locked_q;
            if (locked_q) begin
              cnt_d[LedSlot] = CountBits'(cfg_i.led_flash);
            end
          end
        end
      end else begin
        latched_d  = 1'b0;
        lock_cnt_d = locked_q ? CountBits'(cfg_i.unlock_hold) : CountBits'(cfg_i.lock_hold);
      end

      if (mode_pressed_i) begin
        if (mode_cnt_q != '0) begin
          mode_cnt_d = mode_cnt_q - CountBits'(1);
        end else begin
          stop = 1'b1;
        end
      end else begin
        mode_cnt_d = CountBits'(cfg_i.mode_hold);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < NUM_TIMERS; i++) begin
        cnt_q[i] <= '0;
      end
      sec_q      <= '0;
      lock_cnt_q <= '0;
      mode_cnt_q <= '0;
      latched_q  <= 1'b0;
      locked_q   <= 1'b0;
    end else if (step_i) begin
      cnt_q      <= cnt_d;
      sec_q      <= sec_d;
      lock_cnt_q <= lock_cnt_d;
      mode_cnt_q <= mode_cnt_d;
      latched_q  <= latched_d;
      locked_q   <= locked_d;
    end
  end

  always_comb begin
    res_o.locked       = locked_d;
    res_o.massage_stop = stop;
    for (int unsigned i = 0; i < NUM_TIMERS; i++) begin
      res_o.busy_mask[i] = (cnt_d[i] != '0);
    end
  end

endmodule

`default_nettype wire

/* sv/hlmpt_ramp.sv */
// -----------------------------------------------------------------------------
// Hold, lock and massage phase ticker - massage ramp
// Phase timer, zone rotation, pulse direction and the three drive levels.
// -----------------------------------------------------------------------------
`default_nettype none

module hlmpt_ramp #(
  parameter int unsigned PhaseSteps = hlmpt_pkg::PHASE_STEPS_DEF,
  parameter int unsigned CountBits  = hlmpt_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          load_i,
  input  logic [hlmpt_pkg::INTEN_W-1:0] intensity_i,
  input  hlmpt_pkg::cfg_t               cfg_i,
  output hlmpt_pkg::ramp_res_t          res_o
);
  import hlmpt_pkg::*;

  localparam logic [PHASE_W-1:0] PhaseLast = PHASE_W'(PhaseSteps);
  localparam int unsigned        ProdW     = INTEN_W + FRAC_W;

  logic [CountBits-1:0] pcnt_q, pcnt_d;
  logic [PHASE_W-1:0]   phase_q, phase_d, phase_inc;
  logic [ROT_W-1:0]     rot_q, rot_d;
  logic                 dir_q, dir_d;
  logic [LEVEL_W-1:0]   in_q, in_d, out_q, out_d, steady_q, steady_d;
  logic                 wrap;
  logic [FRAC_W-1:0]    frac_tbl [PHASE_ENTRIES];
  logic [ProdW-1:0]     prod;
  logic [INTEN_W-1:0]   lin, lout;

  // ceil(phase * 2^FRAC_SHIFT / PhaseSteps): exact floor for 8-bit intensity
  for (genvar p = 0; p < PHASE_ENTRIES; p++) begin : g_frac
    localparam int unsigned Frac =
      (p <= PhaseSteps) ? ((p << FRAC_SHIFT) + PhaseSteps - 1) / PhaseSteps : 0;
    assign frac_tbl[p] = FRAC_W'(Frac);
  end

  assign wrap      = (phase_q >= PhaseLast);
  assign phase_inc = wrap ? PHASE_W'(1) : phase_q + PHASE_W'(1);
  assign prod      = ProdW'(intensity_i) * ProdW'(frac_tbl[phase_inc]);
  assign lin       = prod[FRAC_SHIFT +: INTEN_W];
  assign lout      = intensity_i - lin;

  always_comb begin
    pcnt_d   = pcnt_q;
    phase_d  = phase_q;
    rot_d    = rot_q;
    dir_d    = dir_q;
    in_d     = in_q;
    out_d    = out_q;
    steady_d = steady_q;
    if (!load_i) begin
      if (pcnt_q != '0) begin
        pcnt_d = pcnt_q - CountBits'(1);
      end else begin
        pcnt_d   = CountBits'(cfg_i.phase_step);
        phase_d  = phase_inc;
        rot_d    = rot_q + ROT_W'(wrap);
        dir_d    = dir_q ^ wrap;
        in_d     = LEVEL_W'(lin) + LEVEL_W'(cfg_i.min_drive);
        out_d    = LEVEL_W'(lout) + LEVEL_W'(cfg_i.min_drive);
        steady_d = LEVEL_W'(intensity_i) + LEVEL_W'(cfg_i.min_drive);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q   <= '0;
      phase_q  <= '0;
      rot_q    <= '0;
      dir_q    <= 1'b0;
      in_q     <= '0;
      out_q    <= '0;
      steady_q <= '0;
    end else if (step_i) begin
      pcnt_q   <= pcnt_d;
      phase_q  <= phase_d;
      rot_q    <= rot_d;
      dir_q    <= dir_d;
      in_q     <= in_d;
      out_q    <= out_d;
      steady_q <= steady_d;
    end
  end

  always_comb begin
    res_o.rotation     = rot_d;
    res_o.rising       = dir_d;
    res_o.phase        = phase_d;
    res_o.in_level     = in_d;
    res_o.out_level    = out_d;
    res_o.steady_level = steady_d;
  end

endmodule

`default_nettype wire

/* sv/hold_lock_and_massage_phase_ticker_core.sv */
// -----------------------------------------------------------------------------
// Hold, lock and massage phase ticker - top level
// Tick items update timers, lock, mode hold and massage ramp state; load items set a timer.
//
//   channel  | handshake                     | payload
//   ---------+-------------------------------+----------------------------------
//   in       | in_valid_i / in_stall_o       | req_type, slot, value, buttons, intensity
//   out      | out_valid_o / out_stall_i     | lock, stop, busy mask, ramp state
//   cfg      | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// One item per cycle sustained while the output is not stalled.
// Input register -> single-pass state update -> result register.
// in_stall_o rises only while the input register is full and the result
// register is full and stalled. cfg is always ready; each write is registered.
// Reset clears all but the item and result data and loads register defaults.
// -----------------------------------------------------------------------------
`default_nettype none

module hold_lock_and_massage_phase_ticker_core #(
  parameter int unsigned PhaseSteps = hlmpt_pkg::PHASE_STEPS_DEF,
  parameter int unsigned CountBits  = hlmpt_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             req_type_i,
  input  logic [hlmpt_pkg::SLOT_W-1:0]     timer_slot_i,
  input  logic [hlmpt_pkg::VALUE_W-1:0]    load_value_i,
  input  logic                             lock_pressed_i,
  input  logic                             mode_pressed_i,
  input  logic [hlmpt_pkg::INTEN_W-1:0]    intensity_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             locked_o,
  output logic                             massage_stop_o,
  output logic [hlmpt_pkg::NUM_TIMERS-1:0] timer_busy_mask_o,
  output logic [hlmpt_pkg::ROT_W-1:0]      zone_rotation_o,
  output logic                             pulse_rising_o,
  output logic [hlmpt_pkg::PHASE_W-1:0]    ramp_phase_o,
  output logic [hlmpt_pkg::LEVEL_W-1:0]    ramp_in_level_o,
  output logic [hlmpt_pkg::LEVEL_W-1:0]    ramp_out_level_o,
  output logic [hlmpt_pkg::LEVEL_W-1:0]    steady_level_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hlmpt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [hlmpt_pkg::VALUE_W-1:0]    cfg_data_i
);
  import hlmpt_pkg::*;

  localparam logic ReqLoad = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] load_value;
    logic               lock_btn;
    logic               mode_btn;
    logic [INTEN_W-1:0] intensity;
  } item_t;

  typedef struct packed {
    timer_res_t tmr;
    ramp_res_t  rmp;
  } result_t;

  cfg_t       cfg;
  item_t      item_q;
  result_t    res_q;
  timer_res_t tmr_res;
  ramp_res_t  rmp_res;
  logic       in_full_q, out_full_q;
  logic       advance, in_xfer, is_load;

  assign cfg_ready_o = 1'b1;

  hlmpt_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i & cfg_ready_o),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  assign advance    = in_full_q && (!out_full_q || !out_stall_i);
  assign in_stall_o = in_full_q && out_full_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign is_load    = (item_q.req_type == ReqLoad);

  hlmpt_timers #(
    .CountBits (CountBits)
  ) u_timers (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .load_i         (is_load),
    .slot_i         (item_q.slot),
    .load_value_i   (item_q.load_value),
    .lock_pressed_i (item_q.lock_btn),
    .mode_pressed_i (item_q.mode_btn),
    .cfg_i          (cfg),
    .res_o          (tmr_res)
  );

  hlmpt_ramp #(
    .PhaseSteps (PhaseSteps),
    .CountBits  (CountBits)
  ) u_ramp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .load_i      (is_load),
    .intensity_i (item_q.intensity),
    .cfg_i       (cfg),
    .res_o       (rmp_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q  <= 1'b0;
      out_full_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_full_q <= 1'b1;
      end else if (advance) begin
        in_full_q <= 1'b0;
      end
      if (advance) begin
        out_full_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_full_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= '{
        req_type:   req_type_i,
        slot:       timer_slot_i,
        load_value: load_value_i,
        lock_btn:   lock_pressed_i,
        mode_btn:   mode_pressed_i,
        intensity:  intensity_i
      };
    end
    if (advance) begin
      res_q <= '{tmr: tmr_res, rmp: rmp_res};
    end
  end

  assign out_valid_o       = out_full_q;
  assign locked_o          = res_q.tmr.locked;
  assign massage_stop_o    = res_q.tmr.massage_stop;
  assign timer_busy_mask_o = res_q.tmr.busy_mask;
  assign zone_rotation_o   = res_q.rmp.rotation;
  assign pulse_rising_o    = res_q.rmp.rising;
  assign ramp_phase_o      = res_q.rmp.phase;
  assign ramp_in_level_o   = res_q.rmp.in_level;
  assign ramp_out_level_o  = res_q.rmp.out_level;
  assign steady_level_o    = res_q.rmp.steady_level;

endmodule

`default_nettype wire

/* sv/hlmpt_checker.sv */
// -----------------------------------------------------------------------------
// Hold, lock and massage phase ticker - port checker
// Watches the top-level ports for flow control and level consistency.
// -----------------------------------------------------------------------------
`default_nettype none

`include "hold_lock_and_massage_phase_ticker_core_defines.svh"

module hlmpt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       locked_o,
  input logic       massage_stop_o,
  input logic [7:0] timer_busy_mask_o,
  input logic [1:0] zone_rotation_o,
  input logic       pulse_rising_o,
  input logic [7:0] ramp_phase_o,
  input logic [8:0] ramp_in_level_o,
  input logic [8:0] ramp_out_level_o,
  input logic [8:0] steady_level_o
);

  // a held result stays offered
  `HLMPT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // a held result does not change
  `HLMPT_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i,
    $stable({locked_o, massage_stop_o, timer_busy_mask_o, zone_rotation_o,
             pulse_rising_o, ramp_phase_o, ramp_in_level_o, ramp_out_level_o,
             steady_level_o}))

  // input back-pressure only when the result register is full and blocked
  `HLMPT_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // ramp levels are split from the steady level and never exceed it
  `HLMPT_ASSERT_NOW(a_level_order, clk_i, rst_ni, out_valid_o,
    (ramp_in_level_o <= steady_level_o) && (ramp_out_level_o <= steady_level_o))

endmodule

bind hold_lock_and_massage_phase_ticker_core hlmpt_checker u_hlmpt_checker (.*);

`default_nettype wire

/* dv/hold_lock_and_massage_phase_ticker_core_tb.sv */
// -----------------------------------------------------------------------------
// Hold, lock and massage phase ticker - testbench
// Sends tick and load items with random gaps and output stalls, across several
// register settings. A scoreboard predicts each result and checks every field.
// -----------------------------------------------------------------------------
module hold_lock_and_massage_phase_ticker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hlmpt_pkg::*;

  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned ITEMS_PER_PHASE = 100;
  localparam int unsigned IDLE_LIMIT      = 5000;
  localparam int unsigned HOLD_OFF_CYCLES = 64;
  // early in the back-to-back phase, so the hold-off always lands inside it
  localparam int unsigned HOLD_OFF_AFTER  = 230;
  localparam int unsigned DRAIN_CYCLES    = 6;
  localparam int unsigned MAX_PRINTS      = 30;

  typedef enum logic {REQ_TICK = 1'b0, REQ_LOAD = 1'b1} req_e;

  typedef enum logic [SLOT_W-1:0] {
    SLOT_LIFT_OPEN, SLOT_LIFT_CLOSE, SLOT_BACK_OPEN, SLOT_BACK_CLOSE,
    SLOT_LED, SLOT_HEAT1, SLOT_HEAT2, SLOT_MASSAGE
  } slot_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_DRIVE, REG_LOCK_HOLD, REG_UNLOCK_HOLD, REG_LED_FLASH,
    REG_MODE_HOLD, REG_PHASE_STEP, REG_TICK_PER_SEC, REG_SPARE
  } reg_e;

  typedef struct packed {
    req_e               req;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
    logic               lock_btn;
    logic               mode_btn;
    logic [INTEN_W-1:0] inten;
  } item_t;

  class ticker_scoreboard;
    cfg_t               regs;
    logic [VALUE_W-1:0] timers [NUM_TIMERS];
    logic [VALUE_W-1:0] sec_cnt, lock_cnt, mode_cnt, phase_cnt;
    logic               lock_latch, lock_on, rising;
    logic [ROT_W-1:0]   rot;
    logic [PHASE_W-1:0] phase_num;
    logic [LEVEL_W-1:0] lvl_in, lvl_out, lvl_steady;
    timer_res_t         timer_q[$];
    ramp_res_t          ramp_q[$];
    int unsigned        errors;

    function new();
      regs = '{min_drive: 8'd0, lock_hold: 16'd4500, unlock_hold: 16'd8000,
               led_flash: 16'd1000, mode_hold: 16'd3000, phase_step: 16'd100,
               tick_per_sec: 16'd1000};
      foreach (timers[i]) timers[i] = '0;
      sec_cnt = '0; lock_cnt = '0; mode_cnt = '0; phase_cnt = '0;
      lock_latch = 1'b0; lock_on = 1'b0; rising = 1'b0;
      rot = '0; phase_num = '0;
      lvl_in = '0; lvl_out = '0; lvl_steady = '0;
      errors = 0;
    endfunction

    function void write_reg(reg_e idx, logic [VALUE_W-1:0] data);
      case (idx)
        REG_MIN_DRIVE:    regs.min_drive    = data[INTEN_W-1:0];
        REG_LOCK_HOLD:    regs.lock_hold    = data;
        REG_UNLOCK_HOLD:  regs.unlock_hold  = data;
        REG_LED_FLASH:    regs.led_flash    = data;
        REG_MODE_HOLD:    regs.mode_hold    = data;
        REG_PHASE_STEP:   regs.phase_step   = data;
        REG_TICK_PER_SEC: regs.tick_per_sec = data;
        default: ;
      endcase
    endfunction

    function void note_item(item_t it);
      logic        stop;
      int unsigned lin, lout;
      timer_res_t  t;
      ramp_res_t   r;
      stop = 1'b0;
      if (it.req == REQ_LOAD) begin
        timers[it.slot] = it.value;
      end else begin
        for (int i = 0; i < SLOT_HEAT1; i++)
          if (timers[i] != 0) timers[i]--;
        // seconds prescaler gates the heat and massage timers
        if (sec_cnt != 0) begin
          sec_cnt--;
        end else begin
          sec_cnt = regs.tick_per_sec;
          for (int i = SLOT_HEAT1; i < NUM_TIMERS; i++)
            if (timers[i] != 0) timers[i]--;
        end
        if (it.lock_btn) begin
          if (!lock_latch) begin
            if (lock_cnt != 0) begin
              lock_cnt--;
            end else begin
              lock_latch = 1'b1;
              lock_on    = !lock_on;
              if (!lock_on) timers[SLOT_LED] = regs.led_flash;
            end
          end
        end else begin
          lock_latch = 1'b0;
          lock_cnt   = lock_on ? regs.unlock_hold : regs.lock_hold;
        end
        if (it.mode_btn) begin
          if (mode_cnt != 0) mode_cnt--;
          else stop = 1'b1;
        end else begin
          mode_cnt = regs.mode_hold;
        end
        if (phase_cnt != 0) begin
          phase_cnt--;
        end else begin
          if (phase_num >= PHASE_STEPS_DEF) begin
            phase_num = '0;
            rot++;
            rising = !rising;
          end
          phase_num++;
          phase_cnt  = regs.phase_step;
          lin        = (32'(it.inten) * 32'(phase_num)) / PHASE_STEPS_DEF;
          lout       = 32'(it.inten) - lin;
          lvl_in     = LEVEL_W'(lin + regs.min_drive);
          lvl_out    = LEVEL_W'(lout + regs.min_drive);
          lvl_steady = LEVEL_W'(32'(it.inten) + regs.min_drive);
        end
      end
      t.locked       = lock_on;
      t.massage_stop = stop;
      for (int i = 0; i < NUM_TIMERS; i++) t.busy_mask[i] = (timers[i] != 0);
      r = '{rot, rising, phase_num, lvl_in, lvl_out, lvl_steady};
      timer_q.push_back(t);
      ramp_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task cmp(string name, int unsigned got, int unsigned exp);
      if (got != exp) report($sformatf("%s got %0d exp %0d", name, got, exp));
    endtask

    task check_result(timer_res_t gt, ramp_res_t gr);
      timer_res_t et;
      ramp_res_t  er;
      if (timer_q.size() == 0) begin
        report("result with no item outstanding");
        return;
      end
      et = timer_q.pop_front();
      er = ramp_q.pop_front();
      cmp("locked",          gt.locked,       et.locked);
      cmp("massage_stop",    gt.massage_stop, et.massage_stop);
      cmp("timer_busy_mask", gt.busy_mask,    et.busy_mask);
      cmp("zone_rotation",   gr.rotation,     er.rotation);
      cmp("pulse_rising",    gr.rising,       er.rising);
      cmp("ramp_phase",      gr.phase,        er.phase);
      cmp("ramp_in_level",   gr.in_level,     er.in_level);
      cmp("ramp_out_level",  gr.out_level,    er.out_level);
      cmp("steady_level",    gr.steady_level, er.steady_level);
    endtask
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    req_type_i;
  logic [SLOT_W-1:0]       timer_slot_i;
  logic [VALUE_W-1:0]      load_value_i;
  logic                    lock_pressed_i;
  logic                    mode_pressed_i;
  logic [INTEN_W-1:0]      intensity_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic                    locked_o;
  logic                    massage_stop_o;
  logic [NUM_TIMERS-1:0]   timer_busy_mask_o;
  logic [ROT_W-1:0]        zone_rotation_o;
  logic                    pulse_rising_o;
  logic [PHASE_W-1:0]      ramp_phase_o;
  logic [LEVEL_W-1:0]      ramp_in_level_o;
  logic [LEVEL_W-1:0]      ramp_out_level_o;
  logic [LEVEL_W-1:0]      steady_level_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [VALUE_W-1:0]      cfg_data_i;

  ticker_scoreboard sb = new();
  int unsigned      items_in = 0;
  int unsigned      idle_cycles = 0;

  hold_lock_and_massage_phase_ticker_core i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .req_type_i        (req_type_i),
    .timer_slot_i      (timer_slot_i),
    .load_value_i      (load_value_i),
    .lock_pressed_i    (lock_pressed_i),
    .mode_pressed_i    (mode_pressed_i),
    .intensity_i       (intensity_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .locked_o          (locked_o),
    .massage_stop_o    (massage_stop_o),
    .timer_busy_mask_o (timer_busy_mask_o),
    .zone_rotation_o   (zone_rotation_o),
    .pulse_rising_o    (pulse_rising_o),
    .ramp_phase_o      (ramp_phase_o),
    .ramp_in_level_o   (ramp_in_level_o),
    .ramp_out_level_o  (ramp_out_level_o),
    .steady_level_o    (steady_level_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Holds the item until the transfer, then leaves valid high for the next one
  task send_item(item_t it);
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    req_type_i     <= it.req;
    timer_slot_i   <= it.slot;
    load_value_i   <= it.value;
    lock_pressed_i <= it.lock_btn;
    mode_pressed_i <= it.mode_btn;
    intensity_i    <= it.inten;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
    items_in++;
  endtask

  task write_cfg(reg_e idx, logic [VALUE_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  task program_regs(input logic [VALUE_W-1:0] min_drive, lock_hold, unlock_hold,
                    led_flash, mode_hold, phase_step, per_sec);
    write_cfg(REG_MIN_DRIVE, min_drive);
    write_cfg(REG_LOCK_HOLD, lock_hold);
    write_cfg(REG_UNLOCK_HOLD, unlock_hold);
    write_cfg(REG_LED_FLASH, led_flash);
    write_cfg(REG_MODE_HOLD, mode_hold);
    write_cfg(REG_PHASE_STEP, phase_step);
    write_cfg(REG_TICK_PER_SEC, per_sec);
    write_cfg(REG_SPARE, VALUE_W'($urandom));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Stop offering, wait for every outstanding result, then let the pipe settle
  task drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.timer_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    item_t       it;
    logic        lock_state, mode_state;
    int unsigned r, gap;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    req_type_i     = REQ_TICK;
    timer_slot_i   = SLOT_LIFT_OPEN;
    load_value_i   = '0;
    lock_pressed_i = 1'b0;
    mode_pressed_i = 1'b0;
    intensity_i    = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = REG_MIN_DRIVE;
    cfg_data_i     = '0;
    lock_state     = 1'b0;
    mode_state     = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Default registers; hold counters are still zero, so both buttons act at once
    send_item('{REQ_TICK, SLOT_LIFT_OPEN, 16'd0, 1'b1, 1'b1, 8'd255});
    send_item('{REQ_TICK, SLOT_LIFT_OPEN, 16'd0, 1'b1, 1'b1, 8'd0});
    for (int s = 0; s < NUM_TIMERS; s++)
      send_item('{REQ_LOAD, SLOT_W'(s), 16'hFFFF, 1'b0, 1'b0, 8'd0});
    send_item('{REQ_LOAD, SLOT_LED, 16'd0, 1'b1, 1'b0, 8'd0});
    send_item('{REQ_LOAD, SLOT_MASSAGE, 16'd1, 1'b0, 1'b1, 8'd0});
    send_item('{REQ_TICK, SLOT_LIFT_OPEN, 16'd0, 1'b0, 1'b0, 8'd128});
    drain();

    // Zero hold times: unlock with the LED reload, relock, and max level offset
    program_regs(16'hFFFF, 16'd0, 16'd0, 16'd5, 16'd0, 16'd0, 16'd0);
    send_item('{REQ_TICK, SLOT_LIFT_OPEN, 16'd0, 1'b0, 1'b0, 8'd255});
    send_item('{REQ_TICK, SLOT_LIFT_OPEN, 16'd0, 1'b1, 1'b1, 8'd255});
    send_item('{REQ_TICK, SLOT_LIFT_OPEN, 16'd0, 1'b1, 1'b0, 8'd0});
    send_item('{REQ_TICK, SLOT_LIFT_OPEN, 16'd0, 1'b0, 1'b1, 8'd255});
    send_item('{REQ_TICK, SLOT_LIFT_OPEN, 16'd0, 1'b1, 1'b1, 8'd17});

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      if (p == 0)
        program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      else if (p == 1)
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF);
      else if (p == NUM_PHASES - 1)
        program_regs(VALUE_W'($urandom), VALUE_W'($urandom), VALUE_W'($urandom),
                     VALUE_W'($urandom), VALUE_W'($urandom), VALUE_W'($urandom),
                     VALUE_W'($urandom));
      else
        program_regs(VALUE_W'($urandom), VALUE_W'($urandom_range(0, 6)),
                     VALUE_W'($urandom_range(0, 6)), VALUE_W'($urandom_range(0, 20)),
                     VALUE_W'($urandom_range(0, 6)), VALUE_W'($urandom_range(0, 3)),
                     VALUE_W'($urandom_range(0, 4)));

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // buttons are held for runs of ticks so the hold counters expire
        if ($urandom_range(0, 5) == 0) lock_state = ~lock_state;
        if ($urandom_range(0, 5) == 0) mode_state = ~mode_state;
        it.req      = ($urandom_range(0, 99) < 12) ? REQ_LOAD : REQ_TICK;
        it.slot     = SLOT_W'($urandom_range(0, NUM_TIMERS - 1));
        it.lock_btn = lock_state;
        it.mode_btn = mode_state;
        r = $urandom_range(0, 9);
        if (r < 7)      it.value = VALUE_W'($urandom_range(0, 30));
        else if (r < 9) it.value = VALUE_W'($urandom);
        else            it.value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        r = $urandom_range(0, 9);
        if (r < 8)      it.inten = INTEN_W'($urandom);
        else            it.inten = (r == 8) ? 8'd0 : 8'd255;
        send_item(it);

        // phase 2 runs back to back so the receiver hold-off fills the pipe
        r = $urandom_range(0, 99);
        if (p == 2 || r < 70) gap = 0;
        else if (r < 93)      gap = $urandom_range(1, 3);
        else                  gap = $urandom_range(8, 25);
        if (gap > 0) begin
          @(negedge clk_i);
          in_valid_i <= 1'b0;
          repeat (gap - 1) @(negedge clk_i);
        end
      end
    end
    drain();

    if (sb.errors == 0)
      $display("hold_lock_and_massage_phase_ticker_core_tb: PASS");
    else
      $display("hold_lock_and_massage_phase_ticker_core_tb: FAIL");
    $finish;
  end

  // Result side stall pattern, with one long hold-off
  initial begin
    int unsigned r, len;
    logic        hold_off_done;
    out_stall_i   = 1'b0;
    hold_off_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      r = $urandom_range(0, 99);
      if (!hold_off_done && items_in >= HOLD_OFF_AFTER) begin
        hold_off_done = 1'b1;
        out_stall_i <= 1'b1;
        len = HOLD_OFF_CYCLES;
      end else if (r < 55) begin
        out_stall_i <= 1'b0;
        len = $urandom_range(1, 12);
      end else if (r < 65) begin
        out_stall_i <= 1'b0;
        len = $urandom_range(30, 80);
      end else if (r < 93) begin
        out_stall_i <= 1'b1;
        len = $urandom_range(1, 3);
      end else begin
        out_stall_i <= 1'b1;
        len = $urandom_range(10, 30);
      end
      repeat (len - 1) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(timer_res_t'{locked_o, massage_stop_o, timer_busy_mask_o},
                      ramp_res_t'{zone_rotation_o, pulse_rising_o, ramp_phase_o,
                                  ramp_in_level_o, ramp_out_level_o, steady_level_o});
  end

  // Watchdog: ends the run when no transfer happens on any channel for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("hold_lock_and_massage_phase_ticker_core_tb: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

/* hold_lock_and_massage_phase_ticker_core.f */
+incdir+sv
sv/hlmpt_pkg.sv
sv/hlmpt_cfg.sv
sv/hlmpt_timers.sv
sv/hlmpt_ramp.sv
sv/hold_lock_and_massage_phase_ticker_core.sv
sv/hlmpt_checker.sv
dv/hold_lock_and_massage_phase_ticker_core_tb.sv
